// File: rtl/core/iee_pkg.sv
// Package: shared types, constants and helper functions for the expression evaluator.
package iee_pkg;

  localparam int VALUE_W = 48;
  localparam int STACK_DEPTH_DEF = 8;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    KIND_NUM = 2'd0,
    KIND_OP  = 2'd1,
    KIND_END = 2'd2,
    KIND_NOP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_BAD  = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_POP,
    S_RD_B,
    S_RD_A,
    S_WAIT_A,
    S_START,
    S_ALU,
    S_WRITE,
    S_FINAL,
    S_FINAL_RD,
    S_FINAL_WAIT,
    S_OUT
  } state_t;

  // Handshake between sequencer and arithmetic unit.
  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_ctl_t;

  typedef struct packed {
    logic       done;
    logic       sat;
    logic       div0;
  } alu_sts_t;

  // Multiply/divide (2,3) bind tighter than add/subtract (0,1).
  function automatic logic high_prec(input logic [1:0] code);
    return code[1];
  endfunction

endpackage

// File: rtl/core/iee_if.sv
// Interfaces: valid/ready channels for tokens and results.
interface iee_tok_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic signed [47:0] number_value;
  logic [1:0]  operator_code;
  modport source (output valid, kind, number_value, operator_code, input ready);
  modport sink (input valid, kind, number_value, operator_code, output ready);
endinterface

interface iee_res_if;
  logic        valid;
  logic        ready;
  logic signed [47:0] result_value;
  logic [1:0]  status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

// File: rtl/core/iee_ram.sv
// Generic single-port-write RAM with registered read.
module iee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/iee_alu.sv
// Shared arithmetic unit: add/sub from one registered sum, multiply over partial products,
// divide by restoring shift-subtract one bit a cycle.
module iee_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic signed [47:0]   a,
  input  logic signed [47:0]   b,
  input  iee_pkg::alu_ctl_t    ctl,
  output iee_pkg::alu_sts_t    sts,
  output logic signed [47:0]   r
);
  import iee_pkg::*;

  localparam int DBITS = 48 + FRAC_BITS;
  localparam int CW = $clog2(DBITS + 1);
  localparam logic [47:0] POS_LIM = {1'b0, {47{1'b1}}};
  localparam logic [47:0] NEG_LIM = {1'b1, {47{1'b0}}};

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} astate_t;

  astate_t       st, st_next;
  logic [1:0]    op;
  logic          neg;
  logic [47:0]   ua, ub;
  logic [95:0]   prod;
  logic [1:0]    mstep;
  logic [DBITS-1:0] dq;   // dividend shifting out, quotient shifting in
  logic [48:0]   rem;
  logic [CW-1:0] cnt;
  logic [95:0]   mag_res;
  logic signed [48:0] sum;

  // Magnitudes from inputs.
  logic [47:0] ma, mb;
  assign ma = a[47] ? 48'(-a) : 48'(a);
  assign mb = b[47] ? 48'(-b) : 48'(b);

  // Partial product: 24x24 slices.
  logic [23:0] pa, pb;
  logic [47:0] pp;
  always_comb begin
    pa = mstep[1] ? ua[47:24] : ua[23:0];
    pb = mstep[0] ? ub[47:24] : ub[23:0];
    pp = pa * pb;
  end

  logic [48:0] rsh, rsub;
  always_comb begin
    rsh  = {rem[47:0], dq[DBITS-1]};
    rsub = rsh - {1'b0, ub};
  end

  always_comb begin
    st_next = st;
    case (st)
      A_IDLE: begin
        if (ctl.start) begin
          case (op_t'(ctl.op))
            OP_MUL: st_next = A_MUL;
            OP_DIV: st_next = A_DIV;
            default: st_next = A_FIN;
          endcase
        end
      end
      A_MUL: if (mstep == 2'd3) st_next = A_FIN;
      A_DIV: if (ub == '0 || cnt == CW'(DBITS - 1)) st_next = A_FIN;
      A_FIN: st_next = A_IDLE;
      default: st_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= A_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      A_IDLE: begin
        if (ctl.start) begin
          op    <= ctl.op;
          neg   <= a[47] ^ b[47];
          ua    <= ma;
          ub    <= mb;
          prod  <= '0;
          mstep <= '0;
          dq    <= DBITS'(ma) << FRAC_BITS;
          rem   <= '0;
          cnt   <= '0;
          sum   <= (ctl.op == OP_SUB) ? 49'(a) - 49'(b) : 49'(a) + 49'(b);
        end
      end
      A_MUL: begin
        prod  <= prod + ({48'd0, pp} << (24 * (32'(mstep[0]) + 32'(mstep[1]))));
        mstep <= mstep + 2'd1;
      end
      A_DIV: begin
        cnt <= cnt + 1'b1;
        if (!rsub[48]) begin
          rem <= rsub;
        end else begin
          rem <= rsh;
        end
        dq <= {dq[DBITS-2:0], ~rsub[48]};
      end
      default: ;
    endcase
  end

  // Final magnitude and saturation.
  logic [95:0] shifted;
  logic [47:0] lim;
  logic        over;
  always_comb begin
    shifted = prod >> FRAC_BITS;
    lim = neg ? NEG_LIM : POS_LIM;
    mag_res = '0;
    over = 1'b0;
    r = '0;
    sts.sat = 1'b0;
    sts.div0 = 1'b0;
    sts.done = (st == A_FIN);
    case (op_t'(op))
      OP_ADD, OP_SUB: begin
        r = sum[47:0];
        if (sum[48] != sum[47]) begin
          sts.sat = 1'b1;
          r = sum[48] ? NEG_LIM : POS_LIM;
        end
      end
      OP_MUL, OP_DIV: begin
        mag_res = (op == OP_MUL) ? shifted : 96'(dq);
        over = (mag_res > 96'(lim));
        if (op == OP_DIV && ub == '0) begin
          sts.div0 = 1'b1;
          r = '0;
        end else begin
          if (over) begin
            sts.sat = 1'b1;
            mag_res = 96'(lim);
          end
          r = neg ? 48'(-mag_res[47:0]) : mag_res[47:0];
        end
      end
      default: r = '0;
    endcase
  end
endmodule

// File: rtl/core/infix_expression_evaluator_unit.sv
// Top level: two-stack infix expression evaluator with a shared arithmetic unit.
//
// Usage:
//   tok (sink) takes one token per transfer: kind 0 pushes number_value,
//   kind 1 reduces while the top operator binds at least as tightly and
//   then pushes operator_code, kind 2 reduces everything and emits one
//   result, kind 3 is dropped. res (source) carries result_value/status.
// Timing:
//   A reduction for add/subtract uses one registered sum, multiply
//   sums four 24x24 partial products, and divide makes one quotient
//   bit per cycle over 48+FRAC_BITS bits. An operator or end token
//   is worked through all of its reductions before the next token.
//   tok.ready is high only while the sequencer is idle; one token is in
//   work at a time.
// Reset:
//   rst clears counts, sticky status and the sequencer. Stack memories
//   are not cleared; only entries below the counts are read.
// Stall:
//   A result holds on res until taken; the next token is accepted only
//   after that transfer.
module infix_expression_evaluator_unit #(
  parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  iee_tok_if.sink   tok,
  iee_res_if.source res
);
  import iee_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t  state, state_next;
  logic [CW-1:0] nd, nop;
  logic [1:0]    sticky;
  logic [1:0]    cur_kind, cur_code;
  logic signed [47:0] cur_num, opa, opb, out_val;
  logic [1:0]    out_st, top_op;

  // Operand and operator stack memories.
  logic          d_we, o_we;
  logic [AW-1:0] d_wa, d_ra, o_wa, o_ra;
  logic [47:0]   d_wd, d_rd;
  logic [1:0]    o_wd, o_rd;

  iee_ram #(.WIDTH(48), .DEPTH(STACK_DEPTH)) u_dstk (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
  iee_ram #(.WIDTH(2), .DEPTH(STACK_DEPTH)) u_ostk (
    .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));

  alu_ctl_t alu_ctl;
  alu_sts_t alu_sts;
  logic signed [47:0] alu_r;

  iee_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk(clk), .rst(rst), .a(opa), .b(opb), .ctl(alu_ctl), .sts(alu_sts), .r(alu_r));

  logic full_d, full_o;
  assign full_d = (nd == CW'(STACK_DEPTH));
  assign full_o = (nop == CW'(STACK_DEPTH));

  // Reads: top of operator stack is requested on entry to CHECK.
  always_comb begin
    o_ra = AW'(nop - 1'b1);
    d_ra = (state == S_RD_B || state == S_FINAL || state == S_FINAL_RD) ?
           AW'(nd - 1'b1) : AW'(nd - 2'd2);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (tok.valid) begin
          case (kind_t'(tok.kind))
            KIND_OP, KIND_END: state_next = S_CHECK;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        if (nop == '0) begin
          state_next = (cur_kind == KIND_END) ? S_FINAL : S_IDLE;
        end else if (cur_kind == KIND_END || high_prec(o_rd) || !high_prec(cur_code)) begin
          state_next = (nd < CW'(2)) ? S_POP : S_RD_B;
        end else begin
          state_next = S_IDLE;
        end
      end
      // Wait in S_POP so the new top operator is read before the next CHECK.
      S_POP:    state_next = S_CHECK;
      S_RD_B:   state_next = S_RD_A;
      S_RD_A:   state_next = S_WAIT_A;
      S_WAIT_A: state_next = S_START;
      S_START:  state_next = S_ALU;
      S_ALU:    if (alu_sts.done) state_next = S_WRITE;
      S_WRITE:  state_next = S_CHECK;
      S_FINAL:  state_next = S_FINAL_RD;
      S_FINAL_RD: state_next = S_FINAL_WAIT;
      S_FINAL_WAIT: state_next = S_OUT;
      S_OUT:    if (res.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    tok.ready = (state == S_IDLE);
    res.valid = (state == S_OUT);
    res.result_value = out_val;
    res.status = out_st;
    alu_ctl.start = (state == S_START);
    alu_ctl.op = top_op;
    d_we = 1'b0;
    d_wa = AW'(nd);
    d_wd = cur_num;
    o_we = 1'b0;
    o_wa = AW'(nop);
    o_wd = cur_code;
    if (state == S_IDLE && tok.valid && tok.kind == KIND_NUM && !full_d) begin
      d_we = 1'b1;
      d_wd = tok.number_value;
    end
    if (state == S_CHECK && nop == '0 && cur_kind == KIND_OP && !full_o) begin
      o_we = 1'b1;
    end
    if (state == S_CHECK && nop != '0 && cur_kind == KIND_OP && !high_prec(o_rd)
        && high_prec(cur_code) && !full_o) begin
      o_we = 1'b1;
    end
    if (state == S_WRITE) begin
      d_we = 1'b1;
      d_wa = AW'(nd - 2'd2);
      d_wd = alu_r;
    end
  end

  // Control registers.
  logic [1:0] flag_code;
  logic       flag_en;
  always_comb begin
    flag_en = 1'b0;
    flag_code = ST_BAD;
    case (state)
      S_IDLE: flag_en = tok.valid && tok.kind == KIND_NUM && full_d;
      S_CHECK: begin
        if (nop != '0 && nd < CW'(2) &&
            (cur_kind == KIND_END || high_prec(o_rd) || !high_prec(cur_code))) begin
          flag_en = 1'b1;
        end else if (cur_kind == KIND_OP && full_o && state_next == S_IDLE) begin
          flag_en = 1'b1;
        end
      end
      S_ALU: begin
        flag_en = alu_sts.done && (alu_sts.div0 || alu_sts.sat);
        flag_code = alu_sts.div0 ? ST_DIV0 : ST_SAT;
      end
      S_FINAL: flag_en = (nd != CW'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nd <= '0;
      nop <= '0;
      sticky <= ST_OK;
    end else begin
      state <= state_next;
      if (flag_en && sticky == ST_OK) sticky <= flag_code;
      if (d_we && state == S_IDLE) nd <= nd + 1'b1;
      if (o_we) nop <= nop + 1'b1;
      // Pop the top operator as a reduction begins (or fails for want of operands).
      if (state == S_CHECK && state_next != S_IDLE && state_next != S_FINAL) nop <= nop - 1'b1;
      if (state == S_WRITE) nd <= nd - 1'b1;
      if (state == S_OUT && res.ready) begin
        nd <= '0;
        nop <= '0;
        sticky <= ST_OK;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && tok.valid) begin
      cur_kind <= tok.kind;
      cur_code <= tok.operator_code;
      cur_num  <= tok.number_value;
    end
    if (state == S_CHECK) top_op <= o_rd;
    if (state == S_RD_A) opb <= d_rd;
    if (state == S_WAIT_A) opa <= d_rd;
    if (state == S_FINAL_WAIT) begin
      out_st <= sticky;
      out_val <= (nd == '0 || sticky == ST_DIV0 || sticky == ST_BAD) ? '0 : d_rd;
    end
  end
endmodule
